### rtl/core/lsmc_pkg.sv
// ----------------------------------------------------------------------------
// Laser scan motion cluster: shared package
// Field widths, configuration register codes, queue depth and the structs
// that pass between the front part, the queue and the back part.
// ----------------------------------------------------------------------------
package lsmc_pkg;

	localparam int BEAMS_DEFAULT = 512;
	localparam int RANGE_W       = 12;
	localparam int ANGLE_W       = 12;
	localparam int COORD_W       = 13;
	localparam int COUNT_W       = 10;
	localparam int FIRST_W       = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 12;
	localparam int IN_DATA_W     = 56;
	localparam int OUT_DATA_W    = 112;

	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

	// Depth of the queue between front and back; must be a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_DATA_W-1:0] MOTION_THRESHOLD_RST = 12'd20;
	localparam logic [CFG_DATA_W-1:0] ANGLE_GAP_RST        = 12'd50;
	localparam logic [CFG_DATA_W-1:0] RANGE_GAP_RST        = 12'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOTION_THRESHOLD = 2'd0,
		CFG_ANGLE_GAP        = 2'd1,
		CFG_RANGE_GAP        = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] motion_threshold;
		logic [CFG_DATA_W-1:0] angle_gap;
		logic [CFG_DATA_W-1:0] range_gap;
	} cfg_t;

	// A classified beam as it travels through the queue.
	typedef struct packed {
		logic                      moving;
		logic                      scan_end;
		logic [RANGE_W-1:0]        range_cm;
		logic signed [ANGLE_W-1:0] angle_tenths;
		logic signed [COORD_W-1:0] x_cm;
		logic signed [COORD_W-1:0] y_cm;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]        length;
		logic signed [COORD_W-1:0] x_min;
		logic signed [COORD_W-1:0] x_max;
		logic signed [COORD_W-1:0] y_min;
		logic signed [COORD_W-1:0] y_max;
	} run_t;

	typedef struct packed {
		logic [QLEVEL_W-1:0] level;
	} qstat_t;

	typedef struct packed {
		logic                      moving;
		logic [COUNT_W-1:0]        cluster_number;
		logic                      found;
		logic [FIRST_W-1:0]        best_first_beam;
		logic [COUNT_W-1:0]        best_length;
		logic signed [COORD_W-1:0] box_x_min;
		logic signed [COORD_W-1:0] box_x_max;
		logic signed [COORD_W-1:0] box_y_min;
		logic signed [COORD_W-1:0] box_y_max;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic                      scan_done;
	} res_t;

endpackage

### rtl/core/lsmc_front.sv
// ----------------------------------------------------------------------------
// Laser scan motion cluster: front part
// Numbers the beams, keeps the background ranges and marks moving beams.
// ----------------------------------------------------------------------------
module lsmc_front #(
	parameter int BEAMS = lsmc_pkg::BEAMS_DEFAULT,
	parameter int IDX_W = $clog2(BEAMS)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [lsmc_pkg::CFG_DATA_W-1:0]       motion_threshold,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  in_learn_n,
	input  logic [lsmc_pkg::RANGE_W-1:0]          in_range,
	input  logic signed [lsmc_pkg::ANGLE_W-1:0]   in_angle,
	input  logic signed [lsmc_pkg::COORD_W-1:0]   in_x,
	input  logic signed [lsmc_pkg::COORD_W-1:0]   in_y,
	input  logic                                  in_last,
	output logic                                  push,
	input  logic                                  push_ready,
	output lsmc_pkg::item_t                       push_item,
	output logic [IDX_W-1:0]                      push_idx
);
	import lsmc_pkg::*;

	logic [RANGE_W-1:0]        bg_mem [BEAMS];
	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W:0]            idx_inc;
	logic [IDX_W-1:0]          idx_next;
	logic                      accept;
	logic                      valid_s1;
	logic                      detect_s1;
	logic                      last_s1;
	logic [RANGE_W-1:0]        range_s1;
	logic [RANGE_W-1:0]        bg_s1;
	logic signed [ANGLE_W-1:0] angle_s1;
	logic signed [COORD_W-1:0] x_s1;
	logic signed [COORD_W-1:0] y_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic signed [RANGE_W:0]   drop;

	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1 || push_ready;
	assign push     = valid_s1 && push_ready;

	assign idx_inc = {1'b0, idx_q} + 1'b1;
	always_comb begin
		if (in_last || (idx_inc >= (IDX_W + 1)'(BEAMS))) begin
			idx_next = '0;
		end else begin
			idx_next = idx_inc[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= idx_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Background memory: a learn beam writes its entry, every beam reads its own.
	always_ff @(posedge clk) begin
		if (accept && !in_learn_n) begin
			bg_mem[idx_q] <= in_range;
		end
		if (accept) begin
			bg_s1 <= bg_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			detect_s1 <= in_learn_n;
			last_s1   <= in_last;
			range_s1  <= in_range;
			angle_s1  <= in_angle;
			x_s1      <= in_x;
			y_s1      <= in_y;
			idx_s1    <= idx_q;
		end
	end

	assign drop = $signed({1'b0, bg_s1}) - $signed({1'b0, range_s1});

	always_comb begin
		push_item.moving       = detect_s1 && (drop > $signed({1'b0, motion_threshold}));
		push_item.scan_end     = last_s1;
		push_item.range_cm     = range_s1;
		push_item.angle_tenths = angle_s1;
		push_item.x_cm         = x_s1;
		push_item.y_cm         = y_s1;
	end
	assign push_idx = idx_s1;

endmodule

### rtl/core/lsmc_queue.sv
// ----------------------------------------------------------------------------
// Laser scan motion cluster: queue
// Short first-in first-out store of classified beams between front and back.
// ----------------------------------------------------------------------------
module lsmc_queue #(
	parameter int IDX_W = $clog2(lsmc_pkg::BEAMS_DEFAULT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 push_ready,
	input  lsmc_pkg::item_t      push_item,
	input  logic [IDX_W-1:0]     push_idx,
	input  logic                 pop,
	output logic                 pop_valid,
	output lsmc_pkg::item_t      pop_item,
	output logic [IDX_W-1:0]     pop_idx,
	output lsmc_pkg::qstat_t     stat
);
	import lsmc_pkg::*;

	item_t               item_q [QUEUE_DEPTH];
	logic [IDX_W-1:0]    idx_q  [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QLEVEL_W-1:0] level_q;

	assign push_ready = (level_q != QLEVEL_W'(QUEUE_DEPTH));
	assign pop_valid  = (level_q != '0);
	assign pop_item   = item_q[rd_ptr_q];
	assign pop_idx    = idx_q[rd_ptr_q];
	assign stat.level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= push_item;
			idx_q[wr_ptr_q]  <= push_idx;
		end
	end

endmodule

### rtl/core/lsmc_back.sv
// ----------------------------------------------------------------------------
// Laser scan motion cluster: back part
// Grows and closes clusters, tracks the longest one and forms the results.
// ----------------------------------------------------------------------------
module lsmc_back #(
	parameter int IDX_W = $clog2(lsmc_pkg::BEAMS_DEFAULT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsmc_pkg::cfg_t       cfg,
	input  logic                 pop_valid,
	output logic                 pop,
	input  lsmc_pkg::item_t      pop_item,
	input  logic [IDX_W-1:0]     pop_idx,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lsmc_pkg::res_t       out_res
);
	import lsmc_pkg::*;

	// Scan state
	logic                      have_prev_q;
	logic [RANGE_W-1:0]        prev_range_q;
	logic signed [ANGLE_W-1:0] prev_angle_q;
	logic [COUNT_W-1:0]        counter_q;
	run_t                      cur_q;
	logic [IDX_W-1:0]          cur_first_q;
	logic                      best_valid_q;
	run_t                      best_q;
	logic [IDX_W-1:0]          best_first_q;

	// Update logic
	logic signed [RANGE_W:0]   dr;
	logic [RANGE_W:0]          dr_abs;
	logic signed [ANGLE_W:0]   da;
	logic                      join_ok;
	logic                      extend;
	logic                      open_new;
	logic                      close1;
	logic                      close2;
	run_t                      cur_new;
	logic [IDX_W-1:0]          cur_first_new;
	logic [COUNT_W-1:0]        counter_new;
	run_t                      best1;
	logic [IDX_W-1:0]          best1_first;
	logic                      best1_valid;
	run_t                      best2;
	logic [IDX_W-1:0]          best2_first;
	logic                      best2_valid;
	logic [IDX_W+FIRST_W-1:0]  first_ext;
	res_t                      res_a;

	// Output stages
	logic                      valid_s1;
	logic                      valid_s2;
	logic                      adv_s1;
	logic                      adv_s2;
	res_t                      res_s1;
	res_t                      res_s2;
	res_t                      res_mid;
	logic signed [COORD_W:0]   sum_x;
	logic signed [COORD_W:0]   sum_y;

	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = pop_valid && adv_s1;

	assign dr     = $signed({1'b0, pop_item.range_cm}) - $signed({1'b0, prev_range_q});
	assign dr_abs = dr[RANGE_W] ? (RANGE_W + 1)'(-dr) : dr;
	assign da     = $signed({pop_item.angle_tenths[ANGLE_W-1], pop_item.angle_tenths})
	              - $signed({prev_angle_q[ANGLE_W-1], prev_angle_q});

	assign join_ok = have_prev_q
	              && ((dr_abs < {1'b0, cfg.range_gap})
	               || (da < $signed({1'b0, cfg.angle_gap})));
	assign extend   = pop_item.moving && join_ok && (cur_q.length != '0);
	assign open_new = pop_item.moving && !extend;

	always_comb begin
		cur_new       = cur_q;
		cur_first_new = cur_first_q;
		counter_new   = counter_q;
		if (extend) begin
			if (cur_q.length != COUNT_SAT) begin
				cur_new.length = cur_q.length + 1'b1;
			end
			if ($signed(pop_item.x_cm) > $signed(cur_q.x_max)) cur_new.x_max = pop_item.x_cm;
			if ($signed(pop_item.x_cm) < $signed(cur_q.x_min)) cur_new.x_min = pop_item.x_cm;
			if ($signed(pop_item.y_cm) > $signed(cur_q.y_max)) cur_new.y_max = pop_item.y_cm;
			if ($signed(pop_item.y_cm) < $signed(cur_q.y_min)) cur_new.y_min = pop_item.y_cm;
		end else if (open_new) begin
			if (counter_q != COUNT_SAT) begin
				counter_new = counter_q + 1'b1;
			end
			cur_new.length = COUNT_W'(1);
			cur_new.x_min  = pop_item.x_cm;
			cur_new.x_max  = pop_item.x_cm;
			cur_new.y_min  = pop_item.y_cm;
			cur_new.y_max  = pop_item.y_cm;
			cur_first_new  = pop_idx;
		end
	end

	// A new cluster closes the open one; the end of the scan closes whatever is open.
	assign close1 = open_new && (cur_q.length != '0)
	             && (!best_valid_q || (cur_q.length > best_q.length));
	assign best1       = close1 ? cur_q : best_q;
	assign best1_first = close1 ? cur_first_q : best_first_q;
	assign best1_valid = best_valid_q || close1;

	assign close2 = pop_item.scan_end && (cur_new.length != '0)
	             && (!best1_valid || (cur_new.length > best1.length));
	assign best2       = close2 ? cur_new : best1;
	assign best2_first = close2 ? cur_first_new : best1_first;
	assign best2_valid = best1_valid || close2;

	assign first_ext = {{FIRST_W{1'b0}}, best2_first};

	always_comb begin
		res_a                = '0;
		res_a.moving         = pop_item.moving;
		res_a.cluster_number = pop_item.moving ? counter_new : '0;
		res_a.scan_done      = pop_item.scan_end;
		if (pop_item.scan_end && best2_valid) begin
			res_a.found           = 1'b1;
			res_a.best_first_beam = first_ext[FIRST_W-1:0];
			res_a.best_length     = best2.length;
			res_a.box_x_min       = best2.x_min;
			res_a.box_x_max       = best2.x_max;
			res_a.box_y_min       = best2.y_min;
			res_a.box_y_max       = best2.y_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_range_q <= '0;
			prev_angle_q <= '0;
			counter_q    <= '0;
			cur_q        <= '0;
			cur_first_q  <= '0;
			best_valid_q <= 1'b0;
			best_q       <= '0;
			best_first_q <= '0;
		end else if (pop) begin
			if (pop_item.scan_end) begin
				have_prev_q  <= 1'b0;
				prev_range_q <= '0;
				prev_angle_q <= '0;
				counter_q    <= '0;
				cur_q        <= '0;
				cur_first_q  <= '0;
				best_valid_q <= 1'b0;
				best_q       <= '0;
				best_first_q <= '0;
			end else begin
				// A closed cluster is always replaced by the one a moving beam opens.
				if (pop_item.moving) begin
					have_prev_q  <= 1'b1;
					prev_range_q <= pop_item.range_cm;
					prev_angle_q <= pop_item.angle_tenths;
					cur_q        <= cur_new;
					cur_first_q  <= cur_first_new;
				end
				counter_q    <= counter_new;
				best_valid_q <= best1_valid;
				best_q       <= best1;
				best_first_q <= best1_first;
			end
		end
	end

	// Two result stages: the second adds the box midpoint.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pop;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign sum_x = $signed({res_s1.box_x_min[COORD_W-1], res_s1.box_x_min})
	             + $signed({res_s1.box_x_max[COORD_W-1], res_s1.box_x_max});
	assign sum_y = $signed({res_s1.box_y_min[COORD_W-1], res_s1.box_y_min})
	             + $signed({res_s1.box_y_max[COORD_W-1], res_s1.box_y_max});

	always_comb begin
		res_mid          = res_s1;
		res_mid.center_x = sum_x[COORD_W:1];
		res_mid.center_y = sum_y[COORD_W:1];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s1 <= res_a;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_mid;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

endmodule

### rtl/core/laser_scan_motion_cluster_top.sv
// Path: a beam accepted at the input passes the front stage register, the queue and the
// two result registers of the back part before its result is valid on the output.
// Throughput: one beam per cycle unless the output stalls, set by the back part's cluster update.
// Learn and detect beams mix freely; a learn beam followed at once by a detect of the
// same index sees the new background. Reset clears all scan and handshake state and
// restores the register defaults; the background memory holds no reset value.
// ----------------------------------------------------------------------------
// Laser scan motion cluster: top level
// Background subtraction on a laser scan, grouping of moving beams into
// clusters and a summary of the longest cluster at the end of each scan.
// ----------------------------------------------------------------------------
module laser_scan_motion_cluster_top #(
	parameter int BEAMS = lsmc_pkg::BEAMS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lsmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lsmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Beam input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: range_cm[11:0], angle_tenths[23:12], x_cm[36:24], y_cm[49:37], zero pad
	input  logic [lsmc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// tuser: opcode (0 learn, 1 detect)
	input  logic                                 s_axis_tuser,
	// tlast: scan_end
	input  logic                                 s_axis_tlast,
	// Result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata: moving[0], cluster_number[10:1], found[11], best_first_beam[20:12],
	// best_length[30:21], box_x_min[43:31], box_x_max[56:44], box_y_min[69:57],
	// box_y_max[82:70], center_x[95:83], center_y[108:96], zero pad
	output logic [lsmc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// tlast: scan_done
	output logic                                 m_axis_tlast
);
	import lsmc_pkg::*;

	localparam int IDX_W = $clog2(BEAMS);

	cfg_t             cfg_q;
	logic             push;
	logic             push_ready;
	item_t            push_item;
	logic [IDX_W-1:0] push_idx;
	logic             pop;
	logic             pop_valid;
	item_t            pop_item;
	logic [IDX_W-1:0] pop_idx;
	qstat_t           q_stat;
	res_t             res;

	// Configuration registers. Writes are always taken; an index beyond the
	// register list is accepted and dropped. The user must write only while the
	// block is idle, so no beam in flight sees a change half-way; the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motion_threshold <= MOTION_THRESHOLD_RST;
			cfg_q.angle_gap        <= ANGLE_GAP_RST;
			cfg_q.range_gap        <= RANGE_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MOTION_THRESHOLD: cfg_q.motion_threshold <= cfg_data;
				CFG_ANGLE_GAP:        cfg_q.angle_gap        <= cfg_data;
				CFG_RANGE_GAP:        cfg_q.range_gap        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front part numbers each beam, writes or reads its background entry and
	// decides whether the beam is moving. It only needs the motion threshold.
	lsmc_front #(
		.BEAMS (BEAMS),
		.IDX_W (IDX_W)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.motion_threshold (cfg_q.motion_threshold),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.in_learn_n       (s_axis_tuser),
		.in_range         (s_axis_tdata[11:0]),
		.in_angle         (s_axis_tdata[23:12]),
		.in_x             (s_axis_tdata[36:24]),
		.in_y             (s_axis_tdata[49:37]),
		.in_last          (s_axis_tlast),
		.push             (push),
		.push_ready       (push_ready),
		.push_item        (push_item),
		.push_idx         (push_idx)
	);

	// The queue lets the front keep taking beams while the result side stalls, until it is full.
	lsmc_queue #(
		.IDX_W (IDX_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.push_idx   (push_idx),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_idx    (pop_idx),
		.stat       (q_stat)
	);

	// The back part owns all cluster state, updates it once per beam and
	// registers the result twice before it reaches the output.
	lsmc_back #(
		.IDX_W (IDX_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item),
		.pop_idx   (pop_idx),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {
		3'b000,
		res.center_y,
		res.center_x,
		res.box_y_max,
		res.box_y_min,
		res.box_x_max,
		res.box_x_min,
		res.best_length,
		res.best_first_beam,
		res.found,
		res.cluster_number,
		res.moving
	};
	assign m_axis_tlast = res.scan_done;

`ifndef SYNTHESIS
	// The queue never holds more requests than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= QLEVEL_W'(QUEUE_DEPTH))
		else $error("queue level beyond its depth");

	// A summary is only ever reported on the last beam of a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.found) |-> res.scan_done)
		else $error("summary reported before scan end");

	// A moving beam always carries a cluster number and a still beam never does.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.moving == (res.cluster_number != '0)))
		else $error("cluster number does not match moving flag");

	// The reported box is well ordered.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.found) |->
		(($signed(res.box_x_min) <= $signed(res.box_x_max)) &&
		 ($signed(res.box_y_min) <= $signed(res.box_y_max))))
		else $error("cluster box minimum above maximum");
`endif

endmodule

### sim/lsmc_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser scan motion cluster: result checker
// Watches the configuration, beam and result channels. Keeps its own model
// of the background, the open cluster and the best cluster, and compares
// every result request, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module lsmc_scan_checker #(
	parameter int BEAMS = lsmc_pkg::BEAMS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [lsmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lsmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 beam_valid,
	input  logic                                 beam_ready,
	input  logic [lsmc_pkg::IN_DATA_W-1:0]       beam_data,
	input  logic                                 beam_op,
	input  logic                                 beam_last,
	input  logic                                 result_valid,
	input  logic                                 result_ready,
	input  logic [lsmc_pkg::OUT_DATA_W-1:0]      result_data,
	input  logic                                 result_last,
	output int                                   error_count,
	output int                                   pending_results,
	output int                                   moving_beams,
	output int                                   scans_closed
);
	import lsmc_pkg::*;

	localparam logic OP_LEARN    = 1'b0;
	localparam int   COUNT_LIMIT = (1 << COUNT_W) - 1;
	localparam int   RESULT_BITS = 109;

	typedef struct {
		int first;
		int length;
		int x_lo;
		int x_hi;
		int y_lo;
		int y_hi;
	} cluster_box_t;

	logic [RANGE_W-1:0] bg_mem [BEAMS];
	int           motion_threshold, angle_gap, range_gap;
	int           beam_idx, prev_range, prev_angle, cluster_count;
	bit           have_prev, best_valid;
	cluster_box_t open_box, best_box;
	res_t         awaited_results [$];
	res_t         want_res, seen_res;
	int           errs, moving_tally, scan_tally;

	function automatic void close_cluster();
		if (open_box.length == 0)
			return;
		if (!best_valid || open_box.length > best_box.length) begin
			best_box   = open_box;
			best_valid = 1'b1;
		end
		open_box = '{default: 0};
	endfunction

	function automatic void clear_scan();
		beam_idx      = 0;
		have_prev     = 1'b0;
		prev_range    = 0;
		prev_angle    = 0;
		cluster_count = 0;
		open_box      = '{default: 0};
		best_valid    = 1'b0;
		best_box      = '{default: 0};
	endfunction

	// Works out the result of one beam and moves the scan state on.
	function automatic res_t classify_beam(input logic op, input logic [IN_DATA_W-1:0] data,
			input logic last);
		res_t r;
		int   range_cm, angle, x, y, drop, range_step, angle_step, mid;
		bit   joins;
		r        = '0;
		range_cm = data[11:0];
		angle    = $signed(data[23:12]);
		x        = $signed(data[36:24]);
		y        = $signed(data[49:37]);
		if (op == OP_LEARN) begin
			bg_mem[beam_idx] = data[11:0];
		end else begin
			drop = int'(bg_mem[beam_idx]) - range_cm;
			if (drop > motion_threshold) begin
				joins = 1'b0;
				if (have_prev) begin
					range_step = range_cm - prev_range;
					if (range_step < 0)
						range_step = -range_step;
					angle_step = angle - prev_angle;
					joins = (range_step < range_gap) || (angle_step < angle_gap);
				end
				if (joins && open_box.length != 0) begin
					if (open_box.length < COUNT_LIMIT)
						open_box.length++;
					if (x > open_box.x_hi) open_box.x_hi = x;
					if (x < open_box.x_lo) open_box.x_lo = x;
					if (y > open_box.y_hi) open_box.y_hi = y;
					if (y < open_box.y_lo) open_box.y_lo = y;
				end else begin
					close_cluster();
					if (cluster_count < COUNT_LIMIT)
						cluster_count++;
					open_box = '{first: beam_idx, length: 1, x_lo: x, x_hi: x, y_lo: y, y_hi: y};
				end
				have_prev        = 1'b1;
				prev_range       = range_cm;
				prev_angle       = angle;
				r.moving         = 1'b1;
				r.cluster_number = cluster_count[COUNT_W-1:0];
				moving_tally++;
			end
		end
		if (last) begin
			close_cluster();
			r.scan_done = 1'b1;
			if (best_valid) begin
				r.found           = 1'b1;
				r.best_first_beam = best_box.first[FIRST_W-1:0];
				r.best_length     = best_box.length[COUNT_W-1:0];
				r.box_x_min       = best_box.x_lo[COORD_W-1:0];
				r.box_x_max       = best_box.x_hi[COORD_W-1:0];
				r.box_y_min       = best_box.y_lo[COORD_W-1:0];
				r.box_y_max       = best_box.y_hi[COORD_W-1:0];
				mid               = (best_box.x_lo + best_box.x_hi) >>> 1;
				r.center_x        = mid[COORD_W-1:0];
				mid               = (best_box.y_lo + best_box.y_hi) >>> 1;
				r.center_y        = mid[COORD_W-1:0];
			end
			clear_scan();
			scan_tally++;
		end else begin
			beam_idx = (beam_idx + 1 >= BEAMS) ? 0 : beam_idx + 1;
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errs++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_threshold = MOTION_THRESHOLD_RST;
			angle_gap        = ANGLE_GAP_RST;
			range_gap        = RANGE_GAP_RST;
			clear_scan();
			awaited_results.delete();
			errs            = 0;
			moving_tally    = 0;
			scan_tally      = 0;
			error_count     <= 0;
			pending_results <= 0;
			moving_beams    <= 0;
			scans_closed    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_MOTION_THRESHOLD: motion_threshold = cfg_data;
					CFG_ANGLE_GAP:        angle_gap        = cfg_data;
					CFG_RANGE_GAP:        range_gap        = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				seen_res.moving          = result_data[0];
				seen_res.cluster_number  = result_data[10:1];
				seen_res.found           = result_data[11];
				seen_res.best_first_beam = result_data[20:12];
				seen_res.best_length     = result_data[30:21];
				seen_res.box_x_min       = result_data[43:31];
				seen_res.box_x_max       = result_data[56:44];
				seen_res.box_y_min       = result_data[69:57];
				seen_res.box_y_max       = result_data[82:70];
				seen_res.center_x        = result_data[95:83];
				seen_res.center_y        = result_data[108:96];
				seen_res.scan_done       = result_last;
				if (awaited_results.size() == 0) begin
					errs++;
					$display("%0t ns: result with no beam waiting for it, expected none, actual %h",
						$time, result_data);
				end else begin
					want_res = awaited_results.pop_front();
					compare_field("moving", want_res.moving, seen_res.moving);
					compare_field("cluster_number", want_res.cluster_number,
						seen_res.cluster_number);
					compare_field("found", want_res.found, seen_res.found);
					compare_field("best_first_beam", want_res.best_first_beam,
						seen_res.best_first_beam);
					compare_field("best_length", want_res.best_length, seen_res.best_length);
					compare_field("box_x_min", $signed(want_res.box_x_min),
						$signed(seen_res.box_x_min));
					compare_field("box_x_max", $signed(want_res.box_x_max),
						$signed(seen_res.box_x_max));
					compare_field("box_y_min", $signed(want_res.box_y_min),
						$signed(seen_res.box_y_min));
					compare_field("box_y_max", $signed(want_res.box_y_max),
						$signed(seen_res.box_y_max));
					compare_field("center_x", $signed(want_res.center_x),
						$signed(seen_res.center_x));
					compare_field("center_y", $signed(want_res.center_y),
						$signed(seen_res.center_y));
					compare_field("scan_done", want_res.scan_done, seen_res.scan_done);
					compare_field("tdata padding", 0, result_data[OUT_DATA_W-1:RESULT_BITS]);
				end
			end
			if (beam_valid && beam_ready)
				awaited_results.push_back(classify_beam(beam_op, beam_data, beam_last));
			error_count     <= errs;
			pending_results <= awaited_results.size();
			moving_beams    <= moving_tally;
			scans_closed    <= scan_tally;
		end
	end

endmodule

### sim/tb_laser_scan_motion_cluster_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser scan motion cluster: testbench top
// Fills the background, runs a handful of hand-built scans and then random
// scans under several threshold and gap settings.
// A separate checker predicts and compares every result request.
// ----------------------------------------------------------------------------
module tb_laser_scan_motion_cluster_top;
	import lsmc_pkg::*;

	localparam int   BEAMS        = BEAMS_DEFAULT;
	localparam logic OP_LEARN     = 1'b0;
	localparam logic OP_DETECT    = 1'b1;
	localparam int   STALL_LIMIT  = 2000;
	localparam int   DRAIN_CYCLES = 8;
	localparam int   COORD_MIN    = -4096;
	localparam int   COORD_MAX    = 4095;
	localparam int   ANGLE_MIN    = -1800;
	localparam int   ANGLE_MAX    = 1800;
	localparam int   RANGE_MAX    = 4095;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   m_axis_tlast;

	int error_count, pending_results, moving_beams, scans_closed;

	// The stimulus keeps its own view of the background and the beam index, only
	// so that it can aim detect beams just below or just above the threshold.
	logic [RANGE_W-1:0] bg_shadow [BEAMS];
	int beam_pos;
	int thr_now;
	int beams_sent;
	int quiet_cycles;
	// While set, neither side of the stream inserts idle cycles.
	bit steady_flow;

	laser_scan_motion_cluster_top #(
		.BEAMS(BEAMS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	lsmc_scan_checker #(
		.BEAMS(BEAMS)
	) i_scan_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.beam_valid      (s_axis_tvalid),
		.beam_ready      (s_axis_tready),
		.beam_data       (s_axis_tdata),
		.beam_op         (s_axis_tuser),
		.beam_last       (s_axis_tlast),
		.result_valid    (m_axis_tvalid),
		.result_ready    (m_axis_tready),
		.result_data     (m_axis_tdata),
		.result_last     (m_axis_tlast),
		.error_count     (error_count),
		.pending_results (pending_results),
		.moving_beams    (moving_beams),
		.scans_closed    (scans_closed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The result side stalls at random with a chance of about nine percent, except while the
	// steady stretch is running. The new value is set at the falling edge.
	always @(negedge clk)
		m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 9);

	// Watchdog: a long run of cycles in which no request moves on any channel
	// means the block has hung or a result has gone missing.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no request accepted for %0d cycles, %0d results outstanding.",
					quiet_cycles, pending_results);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Offers one beam and holds it until the block takes it. Before the beam goes
	// out the sender may idle at random, except while the steady stretch is running.
	task automatic send_beam(input logic op, input int range_cm, input int angle, input int x,
			input int y, input logic last);
		@(negedge clk);
		while (!steady_flow && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, 13'(y), 13'(x), 12'(angle), 12'(range_cm)};
		s_axis_tuser  <= op;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_LEARN)
			bg_shadow[beam_pos] = 12'(range_cm);
		beam_pos = last ? 0 : ((beam_pos + 1 >= BEAMS) ? 0 : beam_pos + 1);
		beams_sent++;
	endtask

	task automatic write_register(input cfg_reg_t which, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= 12'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (which == CFG_MOTION_THRESHOLD)
			thr_now = value;
	endtask

	// Registers only change while the block is idle. Every beam gives exactly one
	// result, so once nothing is outstanding the pipeline is empty.
	task automatic set_thresholds(input int motion, input int angle_step, input int range_jump);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results != 0) @(posedge clk);
		write_register(CFG_MOTION_THRESHOLD, motion);
		write_register(CFG_ANGLE_GAP, angle_step);
		write_register(CFG_RANGE_GAP, range_jump);
	endtask

	// One learn pass over every beam index without an end of scan, so the beam
	// index also wraps round to zero. The first 32 entries get fixed values for
	// the hand-built scans; the rest follow a wandering profile.
	task automatic fill_background();
		int level, r;
		level = 3000;
		for (int i = 0; i < BEAMS; i++) begin
			level = clamp(level + int'($urandom_range(0, 200)) - 100, 1500, RANGE_MAX);
			if (i < 32)
				r = (i == 5) ? RANGE_MAX : ((i == 6) ? 0 : 4000);
			else if ($urandom_range(0, 99) < 3)
				r = $urandom_range(0, 1) ? RANGE_MAX : 0;
			else
				r = level;
			send_beam(OP_LEARN, r, ANGLE_MIN + i * 7, int'($urandom_range(0, 8191)) - 4096,
				int'($urandom_range(0, 8191)) - 4096, 1'b0);
		end
	endtask

	// Hand-built scans under the reset settings (threshold 20, both gaps 50).
	task automatic directed_scans();
		// First scan: a still beam, the first moving beam opening a cluster, a beam
		// exactly at the threshold, a break by both range and angle, a join on range,
		// a join on a negative angle step with the range at its extremes, a beam over
		// a zero background, then a third cluster that ties the best in length, so
		// the earlier one must be reported. Coordinates hit both extremes.
		send_beam(OP_DETECT, 4000, ANGLE_MIN, 0, 0, 1'b0);
		send_beam(OP_DETECT, 3979, -1790, COORD_MIN, COORD_MAX, 1'b0);
		send_beam(OP_DETECT, 3980, -1780, 17, -17, 1'b0);
		send_beam(OP_DETECT, 3900, -1700, 100, 200, 1'b0);
		send_beam(OP_DETECT, 3880, -1600, COORD_MAX, COORD_MIN, 1'b0);
		send_beam(OP_DETECT, 0, -1650, -300, 50, 1'b0);
		send_beam(OP_DETECT, 0, -1640, 1, 1, 1'b0);
		send_beam(OP_DETECT, 100, ANGLE_MAX, 500, 600, 1'b0);
		send_beam(OP_DETECT, 140, ANGLE_MAX, 510, 590, 1'b0);
		send_beam(OP_DETECT, 2000, ANGLE_MAX, 520, 580, 1'b1);
		// Second scan: nothing moves and the scan ends on a learn beam.
		send_beam(OP_DETECT, 4000, 0, 0, 0, 1'b0);
		send_beam(OP_LEARN, 4000, 10, 0, 0, 1'b1);
		// Third scan: a two-beam cluster whose box sums are odd and negative, so the
		// centre has to round down.
		send_beam(OP_DETECT, 3000, 0, COORD_MIN, -1, 1'b0);
		send_beam(OP_DETECT, 3010, 10, COORD_MAX, 0, 1'b1);
	endtask

	// Random scans of mostly well-formed beams: angles stepping forwards with the
	// odd backward or large step, coordinates wandering, detect ranges aimed just
	// inside or just outside the threshold. A small share is pure noise, which
	// may also end a scan early.
	task automatic random_scans(input int quota);
		int   sent, scan_len, angle, x, y, r, bg, ceiling, pick;
		logic op, last, noise_last;
		sent = 0;
		while (sent < quota) begin
			scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
				: $urandom_range(1, 40);
			angle = ANGLE_MIN + int'($urandom_range(0, 600));
			x     = int'($urandom_range(0, 8191)) - 4096;
			y     = int'($urandom_range(0, 8191)) - 4096;
			for (int k = 0; k < scan_len; k++) begin
				last = (k == scan_len - 1);
				if ($urandom_range(0, 99) < 8) begin
					noise_last = last || ($urandom_range(0, 15) == 0);
					send_beam(1'($urandom_range(0, 1)), $urandom_range(0, RANGE_MAX),
						int'($urandom_range(0, 3600)) - 1800,
						int'($urandom_range(0, 8191)) - 4096,
						int'($urandom_range(0, 8191)) - 4096, noise_last);
					sent++;
					if (noise_last)
						break;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 85)
						angle += $urandom_range(0, 40);
					else if (pick < 95)
						angle += $urandom_range(41, 400);
					else
						angle -= $urandom_range(1, 100);
					angle = clamp(angle, ANGLE_MIN, ANGLE_MAX);
					x = clamp(x + int'($urandom_range(0, 80)) - 40, COORD_MIN, COORD_MAX);
					y = clamp(y + int'($urandom_range(0, 80)) - 40, COORD_MIN, COORD_MAX);
					op = ($urandom_range(0, 99) < 12) ? OP_LEARN : OP_DETECT;
					bg = int'(bg_shadow[beam_pos]);
					if (op == OP_LEARN) begin
						r = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1000, RANGE_MAX);
					end else if ($urandom_range(0, 99) < 65 && bg > thr_now) begin
						ceiling = bg - thr_now - 1;
						r = ceiling - int'($urandom_range(0, (ceiling < 150) ? ceiling : 150));
					end else begin
						r = clamp(bg - thr_now + int'($urandom_range(0, 300)), 0, RANGE_MAX);
					end
					send_beam(op, r, angle, x, y, last);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_LEARN;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		steady_flow   = 1'b0;
		beam_pos      = 0;
		thr_now       = MOTION_THRESHOLD_RST;
		beams_sent    = 0;
		quiet_cycles  = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		fill_background();
		directed_scans();
		random_scans(30);

		// Lowest settings: any drop moves, and only a negative angle step joins.
		set_thresholds(0, 0, 0);
		random_scans(20);

		// Highest settings: nothing can move at all.
		set_thresholds(RANGE_MAX, 3600, RANGE_MAX);
		random_scans(15);

		// A stretch with no idling on either side.
		steady_flow = 1'b1;
		set_thresholds($urandom_range(0, 300), $urandom_range(0, 200), $urandom_range(0, 400));
		random_scans(60);
		steady_flow = 1'b0;

		repeat (3) begin
			set_thresholds($urandom_range(0, 300), $urandom_range(0, 200),
				$urandom_range(0, 400));
			random_scans(15);
		end

		// Let the last results drain, then give the pipeline a little longer in
		// case anything stray comes out after them.
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d beams in %0d scans, %0d of them moving, under seven settings.",
			beams_sent, scans_closed, moving_beams);
		$display("Included a full background pass with index wrap and a stretch with no idling.");
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### laser_scan_motion_cluster_top.f
rtl/core/lsmc_pkg.sv
rtl/core/lsmc_front.sv
rtl/core/lsmc_queue.sv
rtl/core/lsmc_back.sv
rtl/core/laser_scan_motion_cluster_top.sv
sim/lsmc_scan_checker.sv
sim/tb_laser_scan_motion_cluster_top.sv
